// ===== hw/rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// Used by every module under hw/rtl; no dependencies.
package uer_pkg;

   localparam int unsigned CountBitsDefault  = 16;
   localparam int unsigned MaxSamplesDefault = 8;

   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 16;
   localparam int unsigned DistBits     = 16;
   localparam int unsigned ScaleShift   = 16;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_TRIGGER_WIDTH = 3'd0,
      CSR_ECHO_TIMEOUT  = 3'd1,
      CSR_SETTLE        = 3'd2,
      CSR_SAMPLES       = 3'd3,
      CSR_SCALE         = 3'd4
   } csr_index_type;

   localparam logic [9:0]  TriggerWidthReset = 10'd20;
   localparam logic [15:0] EchoTimeoutReset  = 16'd15000;
   localparam logic [9:0]  SettleReset       = 10'd50;
   localparam logic [3:0]  SamplesReset      = 4'd5;
   localparam logic [15:0] ScaleReset        = 16'd3603;

   typedef struct packed {
      logic [9:0]  trigger_width_ticks;
      logic [15:0] echo_timeout_ticks;
      logic [9:0]  settle_ticks;
      logic [3:0]  samples_per_reading;
      logic [15:0] distance_scale;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TRIG   = 3'd1,
      PH_WAIT   = 3'd2,
      PH_COUNT  = 3'd3,
      PH_SETTLE = 3'd4
   } phase_type;

   typedef struct packed {
      logic                trigger_level;
      logic                busy_res;
      logic                reading_valid;
      logic [DistBits-1:0] distance_sixteenths;
      logic                timeout_seen;
   } rsp_type;

endpackage

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger top level: one input transfer per 1 us tick, one result each.
// Each tick's result is registered in the result buffer. Throughput: one tick per
// cycle while req_ready is high; the sequencer update is a single registered step.
// A two-entry result buffer keeps req_ready high while one result waits.
// Reset (synchronous, active high) idles the sequencer, empties the buffer and
// loads the register defaults.
module ultrasonic_echo_ranger #(
   parameter int unsigned COUNT_BITS  = uer_pkg::CountBitsDefault,
   parameter int unsigned MAX_SAMPLES = uer_pkg::MaxSamplesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_start_request,
   input  logic                             req_echo_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_trigger_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_reading_valid,
   output logic [uer_pkg::DistBits-1:0]     rsp_distance_sixteenths,
   output logic                             rsp_timeout_seen,
   input  logic                             csr_wen,
   input  logic [uer_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [uer_pkg::CsrDataBits-1:0]  csr_wdata
);
   import uer_pkg::*;

   cfg_type cfg;
   rsp_type step_res;
   rsp_type out_res;
   logic    step_en;

   assign step_en = req_valid && req_ready;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uer_engine #(
      .COUNT_BITS  (COUNT_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .start_request (req_start_request),
      .echo_level    (req_echo_level),
      .cfg           (cfg),
      .res           (step_res)
   );

   uer_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (step_res),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (out_res)
   );

   assign rsp_trigger_level       = out_res.trigger_level;
   assign rsp_busy_res            = out_res.busy_res;
   assign rsp_reading_valid       = out_res.reading_valid;
   assign rsp_distance_sixteenths = out_res.distance_sixteenths;
   assign rsp_timeout_seen        = out_res.timeout_seen;

endmodule

// ===== hw/rtl/uer_csr.sv =====
// Configuration registers of the echo ranger, written through a plain write port.
// Depends on uer_pkg.
module uer_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [uer_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [uer_pkg::CsrDataBits-1:0]  csr_wdata,
   output uer_pkg::cfg_type                 cfg
);
   import uer_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_TRIGGER_WIDTH: cfg_in.trigger_width_ticks = csr_wdata[9:0];
            CSR_ECHO_TIMEOUT:  cfg_in.echo_timeout_ticks  = csr_wdata[15:0];
            CSR_SETTLE:        cfg_in.settle_ticks        = csr_wdata[9:0];
            CSR_SAMPLES:       cfg_in.samples_per_reading = csr_wdata[3:0];
            CSR_SCALE:         cfg_in.distance_scale      = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_width_ticks <= TriggerWidthReset;
         cfg_ff.echo_timeout_ticks  <= EchoTimeoutReset;
         cfg_ff.settle_ticks        <= SettleReset;
         cfg_ff.samples_per_reading <= SamplesReset;
         cfg_ff.distance_scale      <= ScaleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/uer_scale.sv =====
// Sum-to-distance scaler: multiply by reciprocal, round half up, saturate to 16 bits.
// Depends on uer_pkg.
module uer_scale #(
   parameter int unsigned SUM_BITS = 19
) (
   input  logic [SUM_BITS-1:0]          echo_sum,
   input  logic [15:0]                  scale,
   output logic [uer_pkg::DistBits-1:0] distance
);
   import uer_pkg::*;

   localparam int unsigned PROD_BITS = SUM_BITS + 17;
   localparam int unsigned SH_BITS   = PROD_BITS - ScaleShift;
   localparam int unsigned CMP_BITS  = (SH_BITS > DistBits) ? SH_BITS : DistBits + 1;

   logic [PROD_BITS-1:0] product;
   logic [PROD_BITS-1:0] rounded;
   logic [SH_BITS-1:0]   shifted;
   logic [CMP_BITS-1:0]  shifted_ext;
   logic                 saturate;

   always_comb begin
      product     = PROD_BITS'(echo_sum) * PROD_BITS'(scale);
      rounded     = product + PROD_BITS'(1 << (ScaleShift - 1));
      shifted     = rounded[PROD_BITS-1:ScaleShift];
      shifted_ext = CMP_BITS'(shifted);
      saturate    = shifted_ext > CMP_BITS'({DistBits{1'b1}});
      distance    = saturate ? {DistBits{1'b1}} : shifted_ext[DistBits-1:0];
   end

endmodule

// ===== hw/rtl/uer_engine.sv =====
// Per-tick ranging sequencer: trigger, echo wait, echo count, settle, reading.
// Depends on uer_pkg and uer_scale.
module uer_engine #(
   parameter int unsigned COUNT_BITS  = uer_pkg::CountBitsDefault,
   parameter int unsigned MAX_SAMPLES = uer_pkg::MaxSamplesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic             start_request,
   input  logic             echo_level,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type res
);
   import uer_pkg::*;

   localparam int unsigned SUM_BITS = COUNT_BITS + $clog2(MAX_SAMPLES);
   localparam int unsigned IDX_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned TGT_BITS = (IDX_BITS > 4) ? IDX_BITS : 4;
   localparam int unsigned CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [9:0]            timer_ff, timer_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0]   index_ff, index_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                  tflag_ff, tflag_in;
   logic [DistBits-1:0]   dist_ff, dist_in;

   logic [DistBits-1:0]   scaled;
   logic [TGT_BITS-1:0]   target;
   logic                  trig;
   logic                  ready_pulse;
   logic                  done;

   uer_scale #(
      .SUM_BITS (SUM_BITS)
   ) u_scale (
      .echo_sum (sum_ff),
      .scale    (cfg.distance_scale),
      .distance (scaled)
   );

   always_comb begin
      if (cfg.samples_per_reading == 4'd0) begin
         target = TGT_BITS'(1);
      end else if (TGT_BITS'(cfg.samples_per_reading) > TGT_BITS'(MAX_SAMPLES)) begin
         target = TGT_BITS'(MAX_SAMPLES);
      end else begin
         target = TGT_BITS'(cfg.samples_per_reading);
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      tflag_in    = tflag_ff;
      dist_in     = dist_ff;
      trig        = 1'b0;
      ready_pulse = 1'b0;
      done        = 1'b0;

      if (phase_in == PH_IDLE && start_request) begin
         sum_in   = '0;
         index_in = '0;
         tflag_in = 1'b0;
         phase_in = PH_TRIG;
         timer_in = '0;
      end

      if (phase_in == PH_SETTLE) begin
         if (timer_in < cfg.settle_ticks) begin
            timer_in = timer_in + 10'd1;
         end else if (TGT_BITS'(index_in) >= target) begin
            dist_in     = scaled;
            ready_pulse = 1'b1;
            phase_in    = PH_IDLE;
            timer_in    = '0;
         end else begin
            phase_in = PH_TRIG;
            timer_in = '0;
         end
      end

      if (phase_in == PH_TRIG) begin
         trig     = 1'b1;
         timer_in = timer_in + 10'd1;
         if (timer_in >= cfg.trigger_width_ticks) begin
            phase_in = PH_WAIT;
            timer_in = '0;
         end
      end else if (phase_in == PH_WAIT) begin
         if (echo_level) begin
            count_in = '0;
            phase_in = PH_COUNT;
         end
      end

      if (phase_in == PH_COUNT) begin
         if (echo_level) begin
            if (count_in != CountMax) begin
               count_in = count_in + COUNT_BITS'(1);
            end
            if (CMP_BITS'(count_in) >= CMP_BITS'(cfg.echo_timeout_ticks)) begin
               tflag_in = 1'b1;
               done     = 1'b1;
            end
         end else begin
            done = 1'b1;
         end
         if (done) begin
            sum_in   = sum_in + SUM_BITS'(count_in);
            index_in = index_in + IDX_BITS'(1);
            phase_in = PH_SETTLE;
            timer_in = '0;
         end
      end

      res.trigger_level       = trig;
      res.busy_res            = (phase_in != PH_IDLE);
      res.reading_valid       = ready_pulse;
      res.distance_sixteenths = dist_in;
      res.timeout_seen        = tflag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         count_ff <= '0;
         index_ff <= '0;
         sum_ff   <= '0;
         tflag_ff <= 1'b0;
         dist_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         index_ff <= index_in;
         sum_ff   <= sum_in;
         tflag_ff <= tflag_in;
         dist_ff  <= dist_in;
      end
   end

   a_valid_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.reading_valid) |-> !res.busy_res)
      else $error("reading presented while still busy");

   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.trigger_level) |-> res.busy_res)
      else $error("trigger driven outside a reading");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      TGT_BITS'(index_ff) <= TGT_BITS'(MAX_SAMPLES))
      else $error("sample index beyond maximum");

endmodule

// ===== hw/rtl/uer_out_buf.sv =====
// Two-entry result buffer (output register plus skid) between engine and rsp channel.
// Depends on uer_pkg.
module uer_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  uer_pkg::rsp_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output uer_pkg::rsp_type pop_data
);
   import uer_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    pop;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;
   assign pop        = main_valid_ff && pop_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign pop_valid = main_valid_ff;
   assign pop_data  = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !pop) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("skid entry lost without a transfer");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !main_valid_ff) |=> (main_valid_ff && main_ff == $past(push_data)))
      else $error("transfer into empty buffer not captured");

endmodule
